// ----- src/hfx_pkg.sv -----
`timescale 1ns / 1ps

package hfx_pkg;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
	localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

	localparam logic REG_CRC_POLY = 1'b0;
	localparam logic REG_CRC_INIT = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [15:0] given_crc;
		logic        crc_mismatch;
		logic        frame_start;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} queue_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] data,
		input logic [15:0] poly);
		logic [15:0] c;
		c = acc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- src/hfx_queue.sv -----
`timescale 1ns / 1ps

module hfx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hfx_pkg::entry_t push_data,
	input  logic            pop,
	output hfx_pkg::entry_t pop_data,
	output logic            full,
	output logic            empty
);

	hfx_pkg::entry_t                  mem_q [hfx_pkg::QUEUE_DEPTH];
	logic [hfx_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [hfx_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [hfx_pkg::QUEUE_CNT_W-1:0]  count_q;

	assign full     = (count_q == hfx_pkg::QUEUE_CNT_W'(hfx_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty) else $error("queue lost an item");

endmodule

// ----- src/hfx_front.sv -----
`timescale 1ns / 1ps

module hfx_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [23:0]     s_tdata,
	input  logic            s_tlast,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            queue_full,
	output logic            push,
	output hfx_pkg::entry_t push_data
);

	logic [15:0] poly_q;
	logic [15:0] init_q;
	logic [15:0] crc_q;
	logic        open_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;
	assign crc_base = open_q ? crc_q : init_q;
	assign crc_next = hfx_pkg::crc_byte(crc_base, s_tdata[7:0], poly_q);

	always_comb begin
		push_data.data_byte    = s_tdata[7:0];
		push_data.frame_end    = s_tlast;
		push_data.given_crc    = s_tdata[23:8];
		push_data.crc_mismatch = (crc_next != s_tdata[23:8]);
		push_data.frame_start  = !open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= hfx_pkg::CRC_POLY_RESET;
			init_q <= hfx_pkg::CRC_INIT_RESET;
			crc_q  <= hfx_pkg::CRC_INIT_RESET;
			open_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hfx_pkg::REG_CRC_POLY: poly_q <= cfg_data;
					hfx_pkg::REG_CRC_INIT: init_q <= cfg_data;
					default: ;
				endcase
			end
			if (push) begin
				crc_q  <= crc_next;
				open_q <= !s_tlast;
			end
		end
	end

	a_open_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (open_q == !$past(s_tlast))) else $error("frame state not tracked");
	a_start_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_data.frame_start) |-> (crc_base == init_q))
		else $error("frame start without initial CRC");
	a_ready_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		queue_full |-> !push) else $error("item taken while queue full");

endmodule

// ----- src/hfx_back.sv -----
`timescale 1ns / 1ps

module hfx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            queue_empty,
	input  hfx_pkg::entry_t pop_data,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic [1:0]      m_tuser
);

	localparam logic [2:0] PH_FLAG_OPEN  = 3'd0;
	localparam logic [2:0] PH_DATA       = 3'd1;
	localparam logic [2:0] PH_CRC_HI     = 3'd2;
	localparam logic [2:0] PH_CRC_LO     = 3'd3;
	localparam logic [2:0] PH_FLAG_CLOSE = 3'd4;
	localparam logic [2:0] PH_TAIL       = 3'd5;

	hfx_pkg::entry_t ent_q;
	logic            busy_q;
	logic [2:0]      phase_q;
	logic [2:0]      idx_q;
	logic            stuff_q;
	logic [2:0]      ones_q;

	logic            out_valid_q;
	logic            out_bit_q;
	logic            out_last_q;
	logic            out_done_q;
	logic            out_mis_q;

	logic            adv;
	logic            emit;
	logic [7:0]      sel_byte;
	logic            is_flag;
	logic            cur_bit;
	logic            stuff_now;
	logic            item_end;
	logic            done;
	logic [2:0]      phase_next;

	assign adv  = !out_valid_q || m_tready;
	assign emit = adv && busy_q;

	always_comb begin
		unique case (phase_q)
			PH_FLAG_OPEN, PH_FLAG_CLOSE: sel_byte = hfx_pkg::FLAG_BYTE;
			PH_DATA:                     sel_byte = ent_q.data_byte;
			PH_CRC_HI:                   sel_byte = ent_q.given_crc[15:8];
			PH_CRC_LO:                   sel_byte = ent_q.given_crc[7:0];
			default:                     sel_byte = 8'h00;
		endcase
	end

	always_comb begin
		unique case (phase_q)
			PH_FLAG_OPEN:  phase_next = PH_DATA;
			PH_DATA:       phase_next = ent_q.frame_end ? PH_CRC_HI : PH_TAIL;
			PH_CRC_HI:     phase_next = PH_CRC_LO;
			PH_CRC_LO:     phase_next = PH_FLAG_CLOSE;
			default:       phase_next = PH_TAIL;
		endcase
	end

	assign is_flag   = (phase_q == PH_FLAG_OPEN) || (phase_q == PH_FLAG_CLOSE);
	assign cur_bit   = stuff_q ? 1'b0 : sel_byte[idx_q];
	assign stuff_now = !stuff_q && !is_flag && cur_bit && (ones_q == 3'd4);
	assign done      = !stuff_q && (phase_q == PH_FLAG_CLOSE) && (idx_q == 3'd0);

	always_comb begin
		if (stuff_q) begin
			item_end = (phase_q == PH_TAIL);
		end else begin
			item_end = (idx_q == 3'd0) && !stuff_now &&
				(((phase_q == PH_DATA) && !ent_q.frame_end) || (phase_q == PH_FLAG_CLOSE));
		end
	end

	assign pop = adv && (!busy_q || (emit && item_end)) && !queue_empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= pop_data;
		end
		if (adv) begin
			out_bit_q  <= cur_bit;
			out_last_q <= item_end;
			out_done_q <= done;
			out_mis_q  <= done && ent_q.crc_mismatch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_FLAG_OPEN;
			idx_q       <= 3'd7;
			stuff_q     <= 1'b0;
			ones_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (stuff_q || is_flag || !cur_bit || stuff_now) begin
					ones_q <= 3'd0;
				end else begin
					ones_q <= ones_q + 3'd1;
				end
			end
			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= pop_data.frame_start ? PH_FLAG_OPEN : PH_DATA;
				idx_q   <= 3'd7;
				stuff_q <= 1'b0;
			end else if (emit) begin
				if (stuff_q) begin
					stuff_q <= 1'b0;
				end else begin
					if (stuff_now) begin
						stuff_q <= 1'b1;
					end
					idx_q <= idx_q - 3'd1;
					if (idx_q == 3'd0) begin
						phase_q <= phase_next;
					end
				end
				if (item_end) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_bit_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_mis_q, out_done_q};

	a_ones_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q <= 3'd4) else $error("run of ones not stuffed");
	a_stuff_clears: assert property (@(posedge clk) disable iff (!arst_n)
		stuff_q |-> (ones_q == 3'd0)) else $error("stuffed bit with open run");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q) else $error("frame end not item end");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_bit_q)))
		else $error("output changed under stall");

endmodule

// ----- src/hdlc_frame_transmitter.sv -----
`timescale 1ns / 1ps

// HDLC frame transmitter: takes one core byte per input item and sends the frame as a
// serial bit stream, one bit per output item, MSB first, with zero-bit stuffing.
// The first byte of a frame is preceded by the opening flag; the item with s_tlast set
// is followed by its supplied CRC (high byte first) and the closing flag.
// The last bit caused by an input item carries m_tlast. The final closing flag bit
// carries m_tuser[0], and m_tuser[1] then reports that the CRC-16 computed over the
// core bytes differs from the supplied one.
// The front accepts an input item while the queue is not full, runs the CRC update over
// the byte, and writes a two-entry queue. The back pops the queue and shifts one line bit
// per cycle into an output register while the receiver is ready, which sets the sustained
// rate. An accepted item passes through the queue, the back's item register and the
// output register before its first bit appears. When the receiver stalls, the output bit
// holds and the back stops; the front keeps accepting items until the queue fills. Reset
// empties the queue, closes any open frame and restores crc_poly to 0x1021 and crc_init
// to 0xFFFF. Configuration writes through cfg_we, cfg_index and cfg_data are
// registered and apply to items accepted after the write.

module hdlc_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte [7:0], given_crc [23:8]
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_bit [0], zero fill [7:1]
	output logic        m_tlast,   // run_last
	output logic [1:0]  m_tuser,   // frame_done [0], crc_mismatch [1]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	hfx_pkg::queue_ctl_t q_ctl;
	hfx_pkg::entry_t     push_data;
	hfx_pkg::entry_t     pop_data;

	hfx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (q_ctl.full),
		.push       (q_ctl.push),
		.push_data  (push_data)
	);

	hfx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_ctl.push),
		.push_data (push_data),
		.pop       (q_ctl.pop),
		.pop_data  (pop_data),
		.full      (q_ctl.full),
		.empty     (q_ctl.empty)
	);

	hfx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_ctl.empty),
		.pop_data    (pop_data),
		.pop         (q_ctl.pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule
